// ===== src/cron_next_match_time_unit_defines.svh =====
// assertion macros shared by the cron next-match unit
// expects clk and arst_n in the scope where a macro is used
`ifndef CRON_NEXT_MATCH_TIME_UNIT_DEFINES_SVH
`define CRON_NEXT_MATCH_TIME_UNIT_DEFINES_SVH

// same-cycle implication
`define CNMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CNMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/cnmt_pkg.sv =====
// shared types, constants and calendar helpers of the cron next-match unit
// no dependencies
package cnmt_pkg;

	localparam int AFTER_W = 31;
	localparam int CFG_DATA_W = 60;
	localparam int CFG_IDX_W = 3;
	localparam int DAY_W = 21;
	localparam int Z_W = 22;
	localparam int BASE_W = 32;
	localparam int SEARCH_DAYS_DEF = 1832;

	localparam logic [CFG_IDX_W-1:0] REG_MINUTE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOUR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MONTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOM_RESTR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WD_RESTR = 3'd6;

	typedef struct packed {
		logic load;
		logic div_step;
		logic inc;
		logic dinit;
		logic date_step;
		logic dfin;
		logic adv;
		logic hour;
		logic minute;
		logic sum;
		logic miss;
	} cnmt_cmd_t;

	typedef struct packed {
		logic div_done;
		logic date_done;
		logic over;
		logic day_ok;
		logic hour_hit;
		logic min_hit;
	} cnmt_status_t;

	// first set bit at or above lo: {valid, index}
	function automatic logic [5:0] scan24(input logic [23:0] mask, input logic [4:0] lo);
		logic [5:0] r;
		r = '0;
		for (int i = 23; i >= 0; i--) begin
			if (mask[i] && (5'(i) >= lo)) r = {1'b1, 5'(i)};
		end
		return r;
	endfunction

	function automatic logic [6:0] scan60(input logic [59:0] mask, input logic [5:0] lo);
		logic [6:0] r;
		r = '0;
		for (int i = 59; i >= 0; i--) begin
			if (mask[i] && (6'(i) >= lo)) r = {1'b1, 6'(i)};
		end
		return r;
	endfunction

	function automatic logic [2:0] addmod7(input logic [2:0] a, input logic [2:0] b);
		logic [3:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 4'd7) s = s - 4'd7;
		return s[2:0];
	endfunction

	function automatic logic [2:0] mod7_5(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (r >= 5'd28) r = r - 5'd28;
		else if (r >= 5'd21) r = r - 5'd21;
		else if (r >= 5'd14) r = r - 5'd14;
		else if (r >= 5'd7) r = r - 5'd7;
		return r[2:0];
	endfunction

	// calendar month 1-12
	function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
		logic [4:0] r;
		case (mo)
			4'd2: r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

	// march-based month 0-10 (march .. january)
	function automatic logic [4:0] mar_days(input logic [3:0] mp);
		logic [4:0] r;
		case (mp)
			4'd1, 4'd3, 4'd6, 4'd8: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ===== src/cnmt_ifs.sv =====
// valid/ready channels of the cron next-match unit
// depends on cnmt_pkg
interface cnmt_query_if import cnmt_pkg::*; ();
	logic valid;
	logic ready;
	logic [AFTER_W-1:0] after_minute;
	modport source(output valid, output after_minute, input ready);
	modport sink(input valid, input after_minute, output ready);
endinterface

interface cnmt_answer_if import cnmt_pkg::*; ();
	logic valid;
	logic ready;
	logic [AFTER_W-1:0] next_minute;
	logic found;
	modport source(output valid, output next_minute, output found, input ready);
	modport sink(input valid, input next_minute, input found, output ready);
endinterface

// ===== src/cnmt_datapath.sv =====
// datapath: config registers, constant dividers, date walker, hour/minute pick
// depends on cnmt_pkg, driven by cnmt_ctrl
module cnmt_datapath import cnmt_pkg::*; #(
	parameter int SEARCH_DAYS = SEARCH_DAYS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic [AFTER_W-1:0]    after_minute,
	input  cnmt_cmd_t             cmd,
	output cnmt_status_t          status,
	output logic [AFTER_W-1:0]    next_minute,
	output logic                  found
);

	localparam int K_W = $clog2(SEARCH_DAYS + 2);
	localparam logic [K_W-1:0] K_LAST = K_W'(SEARCH_DAYS);
	localparam logic [1:0] DIV_LAST = 2'd3;
	localparam logic [31:0] RCP_1440 = 32'd3054198967;
	localparam logic [21:0] RCP_60 = 22'd2185;
	localparam logic [2:0] LV_ERA = 3'd0;
	localparam logic [2:0] LV_CENT = 3'd1;
	localparam logic [2:0] LV_QUAD = 3'd2;
	localparam logic [2:0] LV_YEAR = 3'd3;
	localparam logic [2:0] LV_MON = 3'd4;
	localparam logic [2:0] LV_DONE = 3'd5;

	logic [59:0] min_mask_q;
	logic [23:0] hour_mask_q;
	logic [30:0] dom_mask_q;
	logic [11:0] mon_mask_q;
	logic [6:0]  wd_mask_q;
	logic        dom_restr_q;
	logic        wd_restr_q;

	logic [AFTER_W-1:0] num_q;
	logic [10:0]        mod_q;
	logic [4:0]         rem_q;
	logic [1:0]         cnt_q;
	logic [5:0]         cm_q;
	logic [4:0]         ch_q;
	logic [DAY_W-1:0]   day_q;
	logic [K_W-1:0]     k_q;
	logic [Z_W-1:0]     z_q;
	logic [2:0]         lvl_q;
	logic [1:0]         c_q;
	logic [4:0]         q_q;
	logic [1:0]         yr_q;
	logic [3:0]         mp_q;
	logic [2:0]         wd_q;
	logic [4:0]         dom_q;
	logic [3:0]         mo_q;
	logic [6:0]         y100_q;
	logic [8:0]         y400_q;
	logic [BASE_W-1:0]  base_q;
	logic [4:0]         h_q;
	logic [5:0]         mi_q;
	logic [AFTER_W-1:0] next_q;
	logic               found_q;

	// split into day, minute of day, hour and minute by reciprocal multiplication
	logic [62:0] day_prod;
	logic [10:0] day_lo;
	logic [21:0] hr_prod;
	logic [10:0] hr_lo;

	always_comb begin
		day_prod = 63'(num_q) * 63'(RCP_1440);
		day_lo = num_q[10:0] * 11'd1440;
		hr_prod = 22'(mod_q) * RCP_60;
		hr_lo = {rem_q, 6'b0} - {4'b0, rem_q, 2'b0};
	end

	// date decomposition step
	logic [Z_W-1:0] dstep;
	logic           dlim;
	logic [2:0]     dinc7;
	logic           dtake;
	logic [4:0]     mlen_mar;

	always_comb begin
		mlen_mar = mar_days(mp_q);
		case (lvl_q)
			LV_ERA: begin
				dstep = Z_W'(146097);
				dlim = 1'b1;
				dinc7 = 3'd0;
			end
			LV_CENT: begin
				dstep = Z_W'(36524);
				dlim = c_q != 2'd3;
				dinc7 = 3'd5;
			end
			LV_QUAD: begin
				dstep = Z_W'(1461);
				dlim = 1'b1;
				dinc7 = 3'd5;
			end
			LV_YEAR: begin
				dstep = Z_W'(365);
				dlim = yr_q != 2'd3;
				dinc7 = 3'd1;
			end
			LV_MON: begin
				dstep = Z_W'(mlen_mar);
				dlim = mp_q < 4'd11;
				dinc7 = (mlen_mar == 5'd31) ? 3'd3 : 3'd2;
			end
			default: begin
				dstep = '0;
				dlim = 1'b0;
				dinc7 = 3'd0;
			end
		endcase
		dtake = dlim && (z_q >= dstep);
	end

	// final date fields
	logic [3:0] fin_mo;
	logic [8:0] fin_y400;
	logic [6:0] fin_y100;

	always_comb begin
		fin_mo = (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
		fin_y100 = {q_q, yr_q};
		fin_y400 = 9'(9'(c_q) * 9'd100) + 9'({q_q, yr_q});
		if (fin_mo <= 4'd2) begin
			fin_y100 = (fin_y100 == 7'd99) ? 7'd0 : fin_y100 + 7'd1;
			fin_y400 = (fin_y400 == 9'd399) ? 9'd0 : fin_y400 + 9'd1;
		end
	end

	// day checks
	logic       leap;
	logic [4:0] mlen;
	logic       mon_ok;
	logic       dom_ok;
	logic       wd_ok;
	logic       rule_ok;
	logic [5:0] hs;
	logic [5:0] lo_min;
	logic [6:0] ms;
	logic [5:0] ns;
	logic [6:0] fs;

	always_comb begin
		leap = (y100_q[1:0] == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));
		mlen = month_days(mo_q, leap);
		mon_ok = mon_mask_q[4'(mo_q - 4'd1)];
		dom_ok = dom_mask_q[5'(dom_q - 5'd1)];
		wd_ok = wd_mask_q[wd_q];
		case ({dom_restr_q, wd_restr_q})
			2'b00: rule_ok = 1'b1;
			2'b01: rule_ok = wd_ok;
			2'b10: rule_ok = dom_ok;
			default: rule_ok = dom_ok || wd_ok;
		endcase
		hs = scan24(hour_mask_q, ch_q);
		lo_min = (h_q == ch_q) ? cm_q : 6'd0;
		ms = scan60(min_mask_q, lo_min);
		ns = scan24(hour_mask_q, h_q + 5'd1);
		fs = scan60(min_mask_q, 6'd0);
	end

	logic [10:0]       hm;
	logic [BASE_W-1:0] res;

	always_comb begin
		hm = {h_q, 6'b0} - {4'b0, h_q, 2'b0};
		res = base_q + BASE_W'(hm) + BASE_W'(mi_q);
	end

	always_comb begin
		status.div_done = cnt_q == DIV_LAST;
		status.date_done = lvl_q == LV_DONE;
		status.over = k_q > K_LAST;
		status.day_ok = mon_ok && rule_ok;
		status.hour_hit = hs[5];
		status.min_hit = ms[6] || ns[5];
	end

	// config and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mask_q <= '1;
			hour_mask_q <= '1;
			dom_mask_q <= '1;
			mon_mask_q <= '1;
			wd_mask_q <= '1;
			dom_restr_q <= 1'b0;
			wd_restr_q <= 1'b0;
			cnt_q <= '0;
			lvl_q <= LV_DONE;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_MINUTE: min_mask_q <= wr_data[59:0];
					REG_HOUR: hour_mask_q <= wr_data[23:0];
					REG_DOM: dom_mask_q <= wr_data[30:0];
					REG_MONTH: mon_mask_q <= wr_data[11:0];
					REG_WEEKDAY: wd_mask_q <= wr_data[6:0];
					REG_DOM_RESTR: dom_restr_q <= wr_data[0];
					REG_WD_RESTR: wd_restr_q <= wr_data[0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (cmd.dinit) lvl_q <= LV_ERA;
			else if (cmd.date_step && !dtake) lvl_q <= lvl_q + 3'd1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= after_minute;
		end
		if (cmd.div_step) begin
			case (cnt_q)
				2'd0: begin
					num_q <= AFTER_W'(day_prod[62:42]);
					mod_q <= num_q[10:0];
				end
				2'd1: mod_q <= mod_q - day_lo;
				2'd2: rem_q <= hr_prod[21:17];
				default: cm_q <= 6'(mod_q - hr_lo);
			endcase
		end
		if (cmd.inc) begin
			if (cm_q == 6'd59) begin
				cm_q <= '0;
				if (rem_q == 5'd23) begin
					ch_q <= '0;
					day_q <= num_q[DAY_W-1:0] + DAY_W'(1);
					k_q <= K_W'(1);
				end else begin
					ch_q <= rem_q + 5'd1;
					day_q <= num_q[DAY_W-1:0];
					k_q <= '0;
				end
			end else begin
				cm_q <= cm_q + 6'd1;
				ch_q <= rem_q;
				day_q <= num_q[DAY_W-1:0];
				k_q <= '0;
			end
		end
		if (cmd.dinit) begin
			z_q <= Z_W'(day_q) + Z_W'(719468);
			base_q <= BASE_W'(day_q) * BASE_W'(1440);
			c_q <= '0;
			q_q <= '0;
			yr_q <= '0;
			mp_q <= '0;
			wd_q <= 3'd3;
		end
		if (cmd.date_step && dtake) begin
			z_q <= z_q - dstep;
			wd_q <= addmod7(wd_q, dinc7);
			case (lvl_q)
				LV_CENT: c_q <= c_q + 2'd1;
				LV_QUAD: q_q <= q_q + 5'd1;
				LV_YEAR: yr_q <= yr_q + 2'd1;
				LV_MON: mp_q <= mp_q + 4'd1;
				default: ;
			endcase
		end
		if (cmd.dfin) begin
			dom_q <= z_q[4:0] + 5'd1;
			wd_q <= addmod7(wd_q, mod7_5(z_q[4:0]));
			mo_q <= fin_mo;
			y100_q <= fin_y100;
			y400_q <= fin_y400;
		end
		if (cmd.adv) begin
			wd_q <= (wd_q == 3'd6) ? 3'd0 : wd_q + 3'd1;
			base_q <= base_q + BASE_W'(1440);
			k_q <= k_q + K_W'(1);
			ch_q <= '0;
			cm_q <= '0;
			if (dom_q == mlen) begin
				dom_q <= 5'd1;
				if (mo_q == 4'd12) begin
					mo_q <= 4'd1;
					y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
					y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
				end else begin
					mo_q <= mo_q + 4'd1;
				end
			end else begin
				dom_q <= dom_q + 5'd1;
			end
		end
		if (cmd.hour) h_q <= hs[4:0];
		if (cmd.minute) begin
			if (ms[6]) begin
				mi_q <= ms[5:0];
			end else begin
				h_q <= ns[4:0];
				mi_q <= fs[5:0];
			end
		end
		if (cmd.sum) begin
			found_q <= !res[BASE_W-1];
			next_q <= res[BASE_W-1] ? '0 : res[AFTER_W-1:0];
		end
		if (cmd.miss) begin
			found_q <= 1'b0;
			next_q <= '0;
		end
	end

	assign next_minute = next_q;
	assign found = found_q;

endmodule

// ===== src/cnmt_ctrl.sv =====
// controller state machine of the cron next-match unit
// depends on cnmt_pkg and the assertion macro header
`include "cron_next_match_time_unit_defines.svh"

module cnmt_ctrl import cnmt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  cnmt_status_t status,
	output cnmt_cmd_t    cmd
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_DIV    = 10'b0000000010,
		ST_INC    = 10'b0000000100,
		ST_DINIT  = 10'b0000001000,
		ST_DATE   = 10'b0000010000,
		ST_DFIN   = 10'b0000100000,
		ST_CHECK  = 10'b0001000000,
		ST_MINUTE = 10'b0010000000,
		ST_SUM    = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} cnmt_state_t;

	cnmt_state_t state_q;
	cnmt_state_t state_n;

	always_comb begin
		cmd = '0;
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) state_n = ST_INC;
			end
			ST_INC: begin
				cmd.inc = 1'b1;
				state_n = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.dinit = 1'b1;
				state_n = ST_DATE;
			end
			ST_DATE: begin
				if (status.date_done) state_n = ST_DFIN;
				else cmd.date_step = 1'b1;
			end
			ST_DFIN: begin
				cmd.dfin = 1'b1;
				state_n = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.over) begin
					cmd.miss = 1'b1;
					state_n = ST_OUT;
				end else if (status.day_ok && status.hour_hit) begin
					cmd.hour = 1'b1;
					state_n = ST_MINUTE;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			ST_MINUTE: begin
				if (status.min_hit) begin
					cmd.minute = 1'b1;
					state_n = ST_SUM;
				end else begin
					cmd.adv = 1'b1;
					state_n = ST_CHECK;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_n = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;

	`CNMT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted word not held busy")
	`CNMT_ASSERT_NEXT(a_div_stays, (state_q == ST_DIV) && !status.div_done, state_q == ST_DIV, "divider left early")
	`CNMT_ASSERT_NEXT(a_sum_to_out, state_q == ST_SUM, out_valid, "sum not presented")
	`CNMT_ASSERT_NEXT(a_over_to_out, (state_q == ST_CHECK) && status.over, out_valid && !in_ready, "window end not reported")

endmodule

// ===== src/cron_next_match_time_unit.sv =====
// Cron next-match unit: returns the first minute after a given time that
// matches the minute, hour, day-of-month, month and weekday masks.
// query channel (valid/ready) carries after_minute, one word per search;
// answer channel carries next_minute and found (found 0 gives next_minute 0).
// wr_en/wr_index/wr_data write the mask registers: 0 minute, 1 hour,
// 2 day of month, 3 month, 4 weekday, 5 dom restricted, 6 weekday restricted;
// unknown indexes are ignored. Write only while no search is running.
// One search at a time: query ready is high only when idle.
// Steps after the query word: split the time into day, hour and minute,
// decompose the day into a date, then check the searched days one by one,
// moving to the next day also when an hour matches but no later minute of
// that day does, over at most SEARCH_DAYS + 1 days, then form the answer.
// The day walk of the search window sets the throughput.
// The answer word is held until taken; a stalled receiver holds the unit.
// Asynchronous reset returns to idle with all masks set and both restricted
// flags clear.
module cron_next_match_time_unit import cnmt_pkg::*; #(
	parameter int SEARCH_DAYS = SEARCH_DAYS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cnmt_query_if.sink            query,
	cnmt_answer_if.source         answer,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	cnmt_cmd_t    cmd;
	cnmt_status_t status;

	cnmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.in_ready  (query.ready),
		.out_valid (answer.valid),
		.out_ready (answer.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cnmt_datapath #(
		.SEARCH_DAYS (SEARCH_DAYS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.after_minute (query.after_minute),
		.cmd          (cmd),
		.status       (status),
		.next_minute  (answer.next_minute),
		.found        (answer.found)
	);

endmodule
